// ===== rtl/core/bcr_pkg.sv =====
`timescale 1ns / 1ps

package bcr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;

    // Row values and results are signed 32 bits.
    localparam int ROW_W  = 32;
    // Doubled Catmull-Rom coefficients grow by up to twelve times a point.
    localparam int COEF_W = ROW_W + 4;
    // Horner partial result: coefficient range plus headroom for rounding.
    localparam int H_W    = ROW_W + 8;
    localparam int PROD_W = H_W + FRAC_BITS + 1;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic signed [H_W-1:0] ROW_MAX = {{(H_W-ROW_W+1){1'b0}}, {(ROW_W-1){1'b1}}};
    localparam logic signed [H_W-1:0] ROW_MIN = {{(H_W-ROW_W+1){1'b1}}, {(ROW_W-1){1'b0}}};

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    // Horner step: which coefficient is added after the multiply.
    typedef enum logic [1:0] {
        STEP_A1,
        STEP_A2,
        STEP_A3
    } step_t;

    typedef struct packed {
        logic       coef_load;
        logic       mul_en;
        logic       add_en;
        step_t      step;
        logic       pass_x;
        logic       row_store;
        logic       out_load;
        logic [1:0] row_idx;
    } ctrl_t;

endpackage

// ===== rtl/core/bcr_cubic_unit.sv =====
`timescale 1ns / 1ps

module bcr_cubic_unit import bcr_pkg::*; (
    input  logic                    aclk,
    input  ctrl_t                   ctrl,
    input  logic signed [ROW_W-1:0] p0,
    input  logic signed [ROW_W-1:0] p1,
    input  logic signed [ROW_W-1:0] p2,
    input  logic signed [ROW_W-1:0] p3,
    input  logic [FRAC_BITS-1:0]    frac,
    output logic signed [ROW_W-1:0] res,
    output logic                    clip
);

    logic signed [COEF_W-1:0] a1_reg, a2_reg, a3_reg;
    logic signed [H_W-1:0]    h_reg, h_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic signed [COEF_W-1:0] pe0, pe1, pe2, pe3;
    logic signed [COEF_W-1:0] a0_c, a1_c, a2_c, a3_c, c_sel;
    logic signed [FRAC_BITS:0] f_s;
    logic signed [ACC_W-1:0]  c_ext, rnd, sum, shifted;
    logic                     last_step;

    assign pe0 = COEF_W'(p0);
    assign pe1 = COEF_W'(p1);
    assign pe2 = COEF_W'(p2);
    assign pe3 = COEF_W'(p3);

    // Doubled coefficients, built from shifts and adds.
    assign a0_c = (pe1 <<< 1) + pe1 - (pe2 <<< 1) - pe2 + pe3 - pe0;
    assign a1_c = (pe0 <<< 1) - (pe1 <<< 2) - pe1 + (pe2 <<< 2) - pe3;
    assign a2_c = pe2 - pe0;
    assign a3_c = pe1 <<< 1;

    assign f_s       = $signed({1'b0, frac});
    assign prod_next = h_reg * f_s;

    always_comb begin
        case (ctrl.step)
            STEP_A1: c_sel = a1_reg;
            STEP_A2: c_sel = a2_reg;
            STEP_A3: c_sel = a3_reg;
            default: c_sel = a1_reg;
        endcase
    end

    // Last step also halves the doubled result; round to nearest, ties up.
    assign last_step = (ctrl.step == STEP_A3);
    assign c_ext     = ACC_W'(c_sel) <<< FRAC_BITS;
    assign rnd       = last_step ? (ACC_W'(1) <<< FRAC_BITS) : (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign sum       = ACC_W'(prod_reg) + c_ext + rnd;
    assign shifted   = last_step ? (sum >>> (FRAC_BITS + 1)) : (sum >>> FRAC_BITS);

    always_comb begin
        h_next = h_reg;
        if (ctrl.coef_load) begin
            h_next = H_W'(a0_c);
        end else if (ctrl.add_en) begin
            h_next = shifted[H_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        h_reg <= h_next;
        if (ctrl.coef_load) begin
            a1_reg <= a1_c;
            a2_reg <= a2_c;
            a3_reg <= a3_c;
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // Saturate to the signed row range.
    always_comb begin
        if (h_reg > ROW_MAX) begin
            res  = ROW_MAX[ROW_W-1:0];
            clip = 1'b1;
        end else if (h_reg < ROW_MIN) begin
            res  = ROW_MIN[ROW_W-1:0];
            clip = 1'b1;
        end else begin
            res  = h_reg[ROW_W-1:0];
            clip = 1'b0;
        end
    end

endmodule

// ===== rtl/core/bcr_seq.sv =====
`timescale 1ns / 1ps

module bcr_seq import bcr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  out_free,
    output logic  s_ready,
    output ctrl_t ctrl
);

    state_t     state_reg, state_next;
    step_t      step_reg, step_next;
    logic       pass_x_reg, pass_x_next;
    logic [1:0] row_count_reg, row_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_A1;
            pass_x_reg    <= 1'b0;
            row_count_reg <= ROW_FIRST;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pass_x_reg    <= pass_x_next;
            row_count_reg <= row_count_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        pass_x_next    = pass_x_reg;
        row_count_next = row_count_reg;
        s_ready        = 1'b0;
        ctrl           = '0;
        ctrl.step      = step_reg;
        ctrl.pass_x    = pass_x_reg;
        ctrl.row_idx   = row_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: begin
                ctrl.coef_load = 1'b1;
                step_next      = STEP_A1;
                state_next     = ST_MUL;
            end
            ST_MUL: begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                ctrl.add_en = 1'b1;
                unique case (step_reg)
                    STEP_A1: begin
                        step_next  = STEP_A2;
                        state_next = ST_MUL;
                    end
                    STEP_A2: begin
                        step_next  = STEP_A3;
                        state_next = ST_MUL;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!pass_x_reg) begin
                    ctrl.row_store = 1'b1;
                    if (row_count_reg == ROW_LAST) begin
                        pass_x_next = 1'b1;
                        state_next  = ST_COEF;
                    end else begin
                        row_count_next = row_count_reg + 2'd1;
                        state_next     = ST_IDLE;
                    end
                end else if (out_free) begin
                    ctrl.out_load  = 1'b1;
                    pass_x_next    = 1'b0;
                    row_count_next = ROW_FIRST;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/bicubic_catmull_rom_interp_core.sv =====
`timescale 1ns / 1ps
// A row request is accepted in IDLE; s_ready returns once the sequencer has run COEF, three
// Horner steps (multiply, then add) and DONE. On the fourth row of a neighborhood DONE
// stores the row and an x pass (COEF, three steps, DONE) follows; m_valid is registered
// from DONE once no earlier result waits on m_ready. No new request is taken before the
// current one is through; both passes share the single multiplier, three steps per cubic.
// Reset (aresetn, synchronous, active low) returns to the first row with no result pending.

module bicubic_catmull_rom_interp_core import bcr_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [FRAC_BITS-1:0]          s_frac_x,
    input  logic [FRAC_BITS-1:0]          s_frac_y,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_0,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_1,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_2,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_3,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [ROW_W-1:0]       m_value,
    output logic                          m_saturated
);

    ctrl_t ctrl;
    logic  out_free;
    logic  s_fire;

    // Captured request payload.
    logic [FRAC_BITS-1:0]          fx_reg, fy_reg;
    logic signed [SAMPLE_BITS-1:0] smp0_reg, smp1_reg, smp2_reg, smp3_reg;

    // Interpolated rows of the current neighborhood; rows 0..2 and the fourth.
    logic signed [ROW_W-1:0] row_val_reg [3];
    logic signed [ROW_W-1:0] last_row_reg;
    logic                    row_clip_reg, row_clip_next;

    logic                    m_valid_reg;
    logic signed [ROW_W-1:0] m_value_reg;
    logic                    m_saturated_reg;

    logic signed [ROW_W-1:0] p0, p1, p2, p3;
    logic [FRAC_BITS-1:0]    frac;
    logic signed [ROW_W-1:0] res;
    logic                    clip;

    assign s_fire   = s_valid && s_ready;
    // The output register can take a new result once the old one is gone.
    assign out_free = !m_valid_reg || m_ready;

    bcr_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctrl     (ctrl)
    );

    // Feed the shared unit: samples along y for each row, stored rows along x on the last.
    always_comb begin
        if (ctrl.pass_x) begin
            p0   = row_val_reg[0];
            p1   = row_val_reg[1];
            p2   = row_val_reg[2];
            p3   = last_row_reg;
            frac = fx_reg;
        end else begin
            p0   = ROW_W'(smp0_reg);
            p1   = ROW_W'(smp1_reg);
            p2   = ROW_W'(smp2_reg);
            p3   = ROW_W'(smp3_reg);
            frac = fy_reg;
        end
    end

    bcr_cubic_unit u_cubic (
        .aclk (aclk),
        .ctrl (ctrl),
        .p0   (p0),
        .p1   (p1),
        .p2   (p2),
        .p3   (p3),
        .frac (frac),
        .res  (res),
        .clip (clip)
    );

    // Row clipping is sticky across one neighborhood; the first row restarts it.
    assign row_clip_next = ((ctrl.row_idx == ROW_FIRST) ? 1'b0 : row_clip_reg) | clip;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fx_reg   <= s_frac_x;
            fy_reg   <= s_frac_y;
            smp0_reg <= s_sample_0;
            smp1_reg <= s_sample_1;
            smp2_reg <= s_sample_2;
            smp3_reg <= s_sample_3;
        end
        if (ctrl.row_store) begin
            if (ctrl.row_idx == ROW_LAST) begin
                last_row_reg <= res;
            end else begin
                row_val_reg[ctrl.row_idx] <= res;
            end
        end
        if (ctrl.out_load) begin
            m_value_reg     <= res;
            m_saturated_reg <= row_clip_reg | clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            row_clip_reg <= 1'b0;
        end else begin
            if (ctrl.row_store) begin
                row_clip_reg <= row_clip_next;
            end
            // Hold the result until taken; load a new one only into a free register.
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_saturated = m_saturated_reg;

endmodule

// ===== rtl/core/bcr_checker.sv =====
`timescale 1ns / 1ps

module bcr_checker import bcr_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [ROW_W-1:0] m_value,
    input logic                    m_saturated
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_saturated))
        else $error("result changed while stalled");

    // Busy right after taking a request.
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // A new result only comes out of the final pass, never straight after a request.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared right after a request");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

endmodule

bind bicubic_catmull_rom_interp_core bcr_checker u_bcr_checker (.*);

// ===== tb/bicubic_catmull_rom_interp_core_tb.sv =====
`timescale 1ns / 1ps

module bicubic_catmull_rom_interp_core_tb;
    import bcr_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS-1:0]          FRAC_MAX = '1;
    localparam logic [FRAC_BITS-1:0]          FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam longint I32_MAX = 2147483647;
    localparam longint I32_MIN = -I32_MAX - 1;
    // Cycles to keep watching after the queue empties, with margin over the longest result latency.
    localparam int DRAIN_CYCLES = 40;
    localparam int ROWS_PER_PHASE = 308;

    typedef struct {
        logic signed [ROW_W-1:0] value;
        logic                    saturated;
    } pixel_t;

    // Track rows of each 4x4 neighborhood and queue the interpolated pixel
    // that every fourth row must produce.
    class pixel_tracker;
        longint row_val[3];
        int     row_idx;
        bit     row_clip;
        pixel_t pending_px[$];
        int     failures;
        int     checked;
        int     sat_seen;

        function new();
            row_idx  = 0;
            row_clip = 1'b0;
            failures = 0;
            checked  = 0;
            sat_seen = 0;
        endfunction

        // Round to nearest, ties toward plus infinity; >>> on longint floors.
        function longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint catmull_rom(longint f, longint p0, longint p1, longint p2,
                                     longint p3);
            longint one, a0, a1, a2, a3, r1, r2;
            one = longint'(1) <<< FRAC_BITS;
            a0  = -p0 + 3 * p1 - 3 * p2 + p3;
            a1  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            a2  = -p0 + p2;
            a3  = 2 * p1;
            r1  = round_shift(a0 * f + a1 * one, FRAC_BITS);
            r2  = round_shift(r1 * f + a2 * one, FRAC_BITS);
            return round_shift(r2 * f + a3 * one, FRAC_BITS + 1);
        endfunction

        function longint clamp32(longint v, inout bit clip);
            if (v > I32_MAX) begin
                clip = 1'b1;
                return I32_MAX;
            end
            if (v < I32_MIN) begin
                clip = 1'b1;
                return I32_MIN;
            end
            return v;
        endfunction

        function void take_row(input logic [FRAC_BITS-1:0] fx, fy,
                               input logic signed [SAMPLE_BITS-1:0] s0, s1, s2, s3);
            bit     clip;
            longint rv;
            pixel_t px;
            clip = 1'b0;
            rv = clamp32(catmull_rom(longint'(fy), s0, s1, s2, s3), clip);
            if (row_idx == 0) row_clip = 1'b0;
            if (row_idx < 3) begin
                row_val[row_idx] = rv;
                row_clip = row_clip | clip;
                row_idx++;
                return;
            end
            clip = clip | row_clip;
            px.value = ROW_W'(clamp32(catmull_rom(longint'(fx), row_val[0], row_val[1],
                                                  row_val[2], rv), clip));
            px.saturated = clip;
            pending_px.push_back(px);
            row_idx  = 0;
            row_clip = 1'b0;
        endfunction

        function void check_result(logic signed [ROW_W-1:0] v, logic s);
            pixel_t want;
            if (pending_px.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel: value=%0d saturated=%0b", v, s);
                return;
            end
            want = pending_px.pop_front();
            checked++;
            if (s === 1'b1) sat_seen++;
            if (v !== want.value || s !== want.saturated) begin
                failures++;
                if (failures <= 10)
                    $display("pixel %0d mismatch: value exp %0d got %0d, saturated exp %0b got %0b",
                             checked, want.value, v, want.saturated, s);
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [FRAC_BITS-1:0]          s_frac_x;
    logic [FRAC_BITS-1:0]          s_frac_y;
    logic signed [SAMPLE_BITS-1:0] s_sample_0;
    logic signed [SAMPLE_BITS-1:0] s_sample_1;
    logic signed [SAMPLE_BITS-1:0] s_sample_2;
    logic signed [SAMPLE_BITS-1:0] s_sample_3;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [ROW_W-1:0]       m_value;
    logic                          m_saturated;

    pixel_tracker tracker = new();

    // Idle chances in percent, and the long receiver hold-off in cycles.
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_left    = 0;
    int rows_sent    = 0;

    bicubic_catmull_rom_interp_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frac_x    (s_frac_x),
        .s_frac_y    (s_frac_y),
        .s_sample_0  (s_sample_0),
        .s_sample_1  (s_sample_1),
        .s_sample_2  (s_sample_2),
        .s_sample_3  (s_sample_3),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_saturated (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one row request from a falling edge; hold it until accepted,
    // then record it and return on the next falling edge.
    task automatic send_row(input logic [FRAC_BITS-1:0] fx, fy,
                            input logic signed [SAMPLE_BITS-1:0] v0, v1, v2, v3);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_frac_x   = fx;
        s_frac_y   = fy;
        s_sample_0 = v0;
        s_sample_1 = v1;
        s_sample_2 = v2;
        s_sample_3 = v3;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        tracker.take_row(fx, fy, v0, v1, v2, v3);
        rows_sent++;
        @(negedge aclk);
    endtask

    // Mix full-range, small, extreme and near-zero samples so the cubic sees
    // large overshoot as well as fine rounding.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int mode;
        mode = $urandom_range(9);
        if (mode < 5) return SAMPLE_BITS'($urandom);
        if (mode < 7) return SAMPLE_BITS'($urandom_range(2000) - 1000);
        case ($urandom_range(4))
            0: return SAMP_MAX;
            1: return SAMP_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_BITS'(1);
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_frac();
        if ($urandom_range(9) < 7) return FRAC_BITS'($urandom);
        case ($urandom_range(3))
            0: return '0;
            1: return FRAC_MAX;
            2: return FRAC_HALF;
            default: return FRAC_BITS'(1);
        endcase
    endfunction

    task automatic run_phase(input int src_pct, input int snk_pct, input int rows);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (rows)
            send_row(pick_frac(), pick_frac(), pick_sample(), pick_sample(),
                     pick_sample(), pick_sample());
    endtask

    // Receiver: drive m_ready on falling edges; a pending hold-off wins over
    // the random stall.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Check every accepted pixel against the oldest queued one.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            tracker.check_result(m_value, m_saturated);
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_frac_x   = '0;
        s_frac_y   = '0;
        s_sample_0 = '0;
        s_sample_1 = '0;
        s_sample_2 = '0;
        s_sample_3 = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed neighborhoods, four rows each.
        // All zero with zero fractions.
        repeat (4) send_row('0, '0, '0, '0, '0, '0);
        // Full-scale positive, fractions at their top.
        repeat (4) send_row(FRAC_MAX, FRAC_MAX, SAMP_MAX, SAMP_MAX, SAMP_MAX, SAMP_MAX);
        // Full-scale negative, zero y fraction.
        repeat (4) send_row(FRAC_MAX, '0, SAMP_MIN, SAMP_MIN, SAMP_MIN, SAMP_MIN);
        // Alternating extremes at half fractions: largest overshoot of the cubic.
        send_row(FRAC_HALF, FRAC_HALF, SAMP_MIN, SAMP_MAX, SAMP_MAX, SAMP_MIN);
        send_row(FRAC_HALF, FRAC_HALF, SAMP_MAX, SAMP_MIN, SAMP_MIN, SAMP_MAX);
        send_row(FRAC_HALF, FRAC_HALF, SAMP_MAX, SAMP_MIN, SAMP_MIN, SAMP_MAX);
        send_row(FRAC_HALF, FRAC_HALF, SAMP_MIN, SAMP_MAX, SAMP_MAX, SAMP_MIN);
        // Opposite pattern with near-edge fractions.
        send_row(FRAC_BITS'(1), FRAC_MAX, SAMP_MAX, SAMP_MIN, SAMP_MIN, SAMP_MAX);
        send_row(FRAC_BITS'(1), FRAC_MAX, SAMP_MIN, SAMP_MAX, SAMP_MAX, SAMP_MIN);
        send_row(FRAC_BITS'(1), FRAC_MAX, SAMP_MIN, SAMP_MAX, SAMP_MAX, SAMP_MIN);
        send_row(FRAC_BITS'(1), FRAC_MAX, SAMP_MAX, SAMP_MIN, SAMP_MIN, SAMP_MAX);
        // Small ramps and one alternating row at half fractions exercise ties in the rounding.
        send_row(FRAC_HALF, FRAC_HALF, 24'sd1, 24'sd2, 24'sd3, 24'sd4);
        send_row(FRAC_HALF, FRAC_HALF, -24'sd1, 24'sd0, 24'sd1, 24'sd2);
        send_row(FRAC_HALF, FRAC_HALF, 24'sd0, -24'sd1, 24'sd0, -24'sd1);
        send_row(FRAC_HALF, FRAC_HALF, 24'sd3, 24'sd1, -24'sd1, -24'sd3);

        // Random rows: slow receiver, then slow sender, then full rate
        // opening with a long receiver hold-off so the core backs up.
        run_phase(13, 82, ROWS_PER_PHASE);
        run_phase(82, 13, ROWS_PER_PHASE);
        hold_left = 300;
        run_phase(0, 0, ROWS_PER_PHASE);
        s_valid = 1'b0;

        // Drain the remaining pixels, then watch for strays.
        while (tracker.pending_px.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d row requests, %0d pixels checked (%0d saturated), %0d failures",
                 rows_sent, tracker.checked, tracker.sat_seen, tracker.failures);
        if (tracker.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("timeout with %0d pixels outstanding", tracker.pending_px.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== bicubic_catmull_rom_interp_core.f =====
rtl/core/bcr_pkg.sv
rtl/core/bcr_cubic_unit.sv
rtl/core/bcr_seq.sv
rtl/core/bicubic_catmull_rom_interp_core.sv
rtl/core/bcr_checker.sv
tb/bicubic_catmull_rom_interp_core_tb.sv
